/* hdl/fqmd_pkg.sv */
// shared types, constants and the divider step for the q16.16 multiply/divide unit
package fqmd_pkg;

    // numerator magnitude width, divisor magnitude width, remainder width
    localparam int NW = 49;
    localparam int DW = 33;
    localparam int RW = DW + 1;

    localparam logic [1:0] REQ_MUL   = 2'd0;
    localparam logic [1:0] REQ_RATIO = 2'd1;
    localparam logic [1:0] REQ_DIV   = 2'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [63:0] ROUND_HALF = 64'sh8000;

    typedef enum logic [1:0] {
        K_MUL   = 2'd0,
        K_DIV   = 2'd1,
        K_CONST = 2'd2
    } t_kind;

    // classified request handed from front to back
    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [NW-1:0]      num;
        logic [DW-1:0]      den;
        logic signed [63:0] prod;
        logic [31:0]        cres;
    } t_work;

    // one slot of the divider pipeline
    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [NW-1:0]      num;
        logic [DW-1:0]      den;
        logic [RW-1:0]      rem;
        logic [NW-1:0]      quo;
        logic signed [63:0] prod;
        logic [31:0]        cres;
    } t_stage;

    // one restoring division step: bring down one numerator bit
    function automatic t_stage div_step(input t_stage s);
        t_stage        o;
        logic [RW-1:0] rsh;
        logic          take;
        o    = s;
        rsh  = {s.rem[RW-2:0], s.num[NW-1]};
        take = (rsh >= {1'b0, s.den});
        o.rem = take ? (rsh - {1'b0, s.den}) : rsh;
        o.quo = {s.quo[NW-2:0], take};
        o.num = {s.num[NW-2:0], 1'b0};
        return o;
    endfunction

endpackage

/* hdl/fqmd_front.sv */
// front end: accepts requests, classifies them and forms product or divider operands
module fqmd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_req_type,
    input  logic signed [31:0]  i_operand_a,
    input  logic signed [31:0]  i_operand_b,
    output logic                o_valid,
    input  logic                i_ready,
    output fqmd_pkg::t_work     o_work
);

    logic            r_valid;
    fqmd_pkg::t_work r_work;
    fqmd_pkg::t_work n_work;

    logic signed [15:0] rn, rd;
    logic [15:0]        rn_mag, rd_mag;
    logic signed [49:0] dn;
    logic [49:0]        dn_mag;
    logic signed [33:0] dd;
    logic [33:0]        dd_mag;

    assign o_in_ready = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_work     = r_work;

    // operand forming and special cases
    always_comb begin
        rn     = i_operand_a[15:0];
        rd     = i_operand_b[15:0];
        rn_mag = rn[15] ? 16'(-rn) : 16'(rn);
        rd_mag = rd[15] ? 16'(-rd) : 16'(rd);
        dn     = (50'(i_operand_a) <<< 17) + 50'(i_operand_b);
        dn_mag = dn[49] ? 50'(-dn) : 50'(dn);
        dd     = 34'(i_operand_b) <<< 1;
        dd_mag = dd[33] ? 34'(-dd) : 34'(dd);

        n_work      = '0;
        n_work.kind = fqmd_pkg::K_CONST;
        n_work.prod = 64'(i_operand_a) * 64'(i_operand_b);
        case (i_req_type)
            fqmd_pkg::REQ_MUL: begin
                n_work.kind = fqmd_pkg::K_MUL;
            end
            fqmd_pkg::REQ_RATIO: begin
                if (rd == 16'sd0) begin
                    n_work.cres = rn[15] ? fqmd_pkg::S32_MIN : fqmd_pkg::S32_MAX;
                end else begin
                    // round half away from zero: (2|n|*65536 + |d|) / (2|d|)
                    n_work.kind = fqmd_pkg::K_DIV;
                    n_work.neg  = rn[15] ^ rd[15];
                    n_work.num  = fqmd_pkg::NW'({rn_mag, 17'd0}) + fqmd_pkg::NW'(rd_mag);
                    n_work.den  = fqmd_pkg::DW'({rd_mag, 1'b0});
                end
            end
            fqmd_pkg::REQ_DIV: begin
                if (i_operand_b == fqmd_pkg::ONE_Q16) begin
                    n_work.cres = i_operand_a;
                end else if (i_operand_b == -fqmd_pkg::ONE_Q16) begin
                    n_work.cres = (i_operand_a == fqmd_pkg::S32_MIN) ?
                                  fqmd_pkg::S32_MAX : 32'(-i_operand_a);
                end else if (i_operand_b == 32'sd0) begin
                    n_work.cres = i_operand_a[31] ? fqmd_pkg::S32_MIN : fqmd_pkg::S32_MAX;
                end else begin
                    // truncate (a*131072 + b) / (2b)
                    n_work.kind = fqmd_pkg::K_DIV;
                    n_work.neg  = dn[49] ^ dd[33];
                    n_work.num  = dn_mag[fqmd_pkg::NW-1:0];
                    n_work.den  = dd_mag[fqmd_pkg::DW-1:0];
                end
            end
            default: begin
                n_work.cres = '0;
            end
        endcase
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_work <= n_work;
        end
    end

endmodule

/* hdl/fqmd_queue.sv */
// two-entry queue between front end and divider pipeline
module fqmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  fqmd_pkg::t_work i_work,
    output logic            o_valid,
    input  logic            i_ready,
    output fqmd_pkg::t_work o_work
);

    fqmd_pkg::t_work r_mem [0:1];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_work;
        end
    end

endmodule

/* hdl/fqmd_back.sv */
// back end: pipelined restoring divider, rounding and saturation, output register
module fqmd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  fqmd_pkg::t_work    i_work,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_fixed_result
);

    localparam int NS = fqmd_pkg::NW;

    logic               r_vld [0:NS];
    fqmd_pkg::t_stage   r_st  [0:NS];
    logic               r_out_valid;
    logic signed [31:0] r_out;
    logic signed [31:0] n_out;
    logic               adv;
    fqmd_pkg::t_stage   fin;
    logic signed [63:0] rsum;
    logic signed [63:0] rsh;

    assign adv            = !r_out_valid || i_out_ready;
    assign o_ready        = adv;
    assign o_out_valid    = r_out_valid;
    assign o_fixed_result = r_out;

    // stage zero load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st[0].kind <= i_work.kind;
            r_st[0].neg  <= i_work.neg;
            r_st[0].num  <= i_work.num;
            r_st[0].den  <= i_work.den;
            r_st[0].rem  <= '0;
            r_st[0].quo  <= '0;
            r_st[0].prod <= i_work.prod;
            r_st[0].cres <= i_work.cres;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (adv) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_st[k+1] <= fqmd_pkg::div_step(r_st[k]);
            end
        end
    end

    // final rounding, sign and saturation
    always_comb begin
        fin  = r_st[NS];
        rsum = fin.prod + fqmd_pkg::ROUND_HALF;
        rsh  = rsum >>> 16;
        case (fin.kind)
            fqmd_pkg::K_MUL: begin
                if (rsh > 64'(fqmd_pkg::S32_MAX)) begin
                    n_out = fqmd_pkg::S32_MAX;
                end else if (rsh < 64'(fqmd_pkg::S32_MIN)) begin
                    n_out = fqmd_pkg::S32_MIN;
                end else begin
                    n_out = rsh[31:0];
                end
            end
            fqmd_pkg::K_DIV: begin
                if (fin.neg) begin
                    if (fin.quo > fqmd_pkg::NW'(33'h1_0000_0000 >> 1)) begin
                        n_out = fqmd_pkg::S32_MIN;
                    end else begin
                        n_out = 32'(-fin.quo[31:0]);
                    end
                end else begin
                    if (fin.quo > fqmd_pkg::NW'(32'h7FFF_FFFF)) begin
                        n_out = fqmd_pkg::S32_MAX;
                    end else begin
                        n_out = fin.quo[31:0];
                    end
                end
            end
            fqmd_pkg::K_CONST: begin
                n_out = fin.cres;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

endmodule

/* hdl/fixed_16_16_mul_ratio_div_unit.sv */
// top level of the q16.16 multiply / ratio / divide unit
//
// input channel: i_in_valid / o_in_ready with i_req_type, i_operand_a, i_operand_b.
//   req type 0 multiplies, 1 divides the low 16-bit integers, 2 divides 16.16 values,
//   3 returns zero. one result per request, in request order.
// output channel: o_out_valid / i_out_ready with o_fixed_result.
// path: a request passes the front register, the queue and the divider input
//   register, then 49 divider stages (one quotient bit each) and finally the
//   output register. every request, multiply included, runs the full pipeline
//   so results stay ordered.
// throughput: one request per cycle when the receiver does not stall; the front
//   end keeps accepting while the two-entry queue has room.
// when the receiver stalls, the whole divider pipeline holds; the queue and
//   front register then fill and o_in_ready drops.
// reset (synchronous, active low) empties the pipeline and the queue; no
//   request is in flight afterwards.
module fixed_16_16_mul_ratio_div_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_fixed_result
);

    logic            f_valid, f_ready;
    fqmd_pkg::t_work f_work;
    logic            q_valid, q_ready;
    fqmd_pkg::t_work q_work;

    // request classification
    fqmd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_work      (f_work)
    );

    // decoupling queue
    fqmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_work  (f_work),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_work  (q_work)
    );

    // execution pipeline
    fqmd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .o_ready        (q_ready),
        .i_work         (q_work),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_fixed_result (o_fixed_result)
    );

endmodule

/* tb/tb.sv */
// self-checking testbench for the q16.16 multiply / ratio / divide unit
module tb;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_req_type;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_fixed_result;

    // expected results in request order
    logic signed [31:0] expected_results[$];
    int  n_errors;
    int  n_results;
    int  n_requests;
    int  idle_pct;
    bit  hold_receiver;
    int  hold_cycles;

    fixed_16_16_mul_ratio_div_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_fixed_result (o_fixed_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // clamp a wide value to the signed 32-bit range
    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return fqmd_pkg::S32_MAX;
        if (v < -128'sd2147483648) return fqmd_pkg::S32_MIN;
        return v[31:0];
    endfunction

    // predicted q16.16 result of one request
    function automatic logic signed [31:0] q16_result(input logic [1:0] kind,
            input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [127:0] wa, wb, p, n, d, q, r;
        wa = a;
        wb = b;
        case (kind)
            fqmd_pkg::REQ_MUL: begin
                p = wa * wb + 128'sd32768;
                // floor division by 65536 is an arithmetic shift
                return clamp32(p >>> 16);
            end
            fqmd_pkg::REQ_RATIO: begin
                n = $signed(a[15:0]);
                d = $signed(b[15:0]);
                if (d == 1) return clamp32(n * 65536);
                if (d == -1) return (n == -32768) ? fqmd_pkg::S32_MAX : clamp32(-n * 65536);
                if (d == 0) return (n < 0) ? fqmd_pkg::S32_MIN : fqmd_pkg::S32_MAX;
                q = (n * 65536) / d;
                r = (n * 65536) % d;
                return clamp32(q + (2 * r) / d);
            end
            fqmd_pkg::REQ_DIV: begin
                if (wb == 128'sd65536) return a;
                if (wb == -128'sd65536) begin
                    return (a == fqmd_pkg::S32_MIN) ? fqmd_pkg::S32_MAX : clamp32(-wa);
                end
                if (wb == 0) return (a < 0) ? fqmd_pkg::S32_MIN : fqmd_pkg::S32_MAX;
                return clamp32((wa * 131072 + wb) / (2 * wb));
            end
            default: return '0;
        endcase
    endfunction

    // send one request and record its expected result
    task automatic send_request(input logic [1:0] kind, input logic signed [31:0] a,
            input logic signed [31:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= kind;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(q16_result(kind, a, b));
        n_requests++;
    endtask

    // receiver: random stalls, plus a long hold-off on demand
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_receiver && hold_cycles < 300) begin
            i_out_ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result fixed_result=%h", o_fixed_result);
                n_errors++;
            end else begin
                if (o_fixed_result !== expected_results[0]) begin
                    $error("fixed_result mismatch: expected %h actual %h",
                           expected_results[0], o_fixed_result);
                    n_errors++;
                end
                void'(expected_results.pop_front());
            end
            n_results++;
        end
    end

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom_range(65535) - 32768;
            1: return ($urandom_range(1) ? 32'sh10000 : -32'sh10000);
            2: return ($urandom_range(1) ? fqmd_pkg::S32_MAX : fqmd_pkg::S32_MIN);
            3: return $signed($urandom_range(3)) - 1;
            default: return $urandom;
        endcase
    endfunction

    // directed corner cases for every operation
    task automatic test_directed();
        send_request(fqmd_pkg::REQ_MUL, fqmd_pkg::S32_MAX, fqmd_pkg::S32_MAX);
        send_request(fqmd_pkg::REQ_MUL, fqmd_pkg::S32_MIN, fqmd_pkg::S32_MIN);
        send_request(fqmd_pkg::REQ_MUL, fqmd_pkg::S32_MIN, fqmd_pkg::S32_MAX);
        send_request(fqmd_pkg::REQ_MUL, fqmd_pkg::ONE_Q16, -32'sd3);
        send_request(fqmd_pkg::REQ_MUL, 32'sh8000, 32'sd1);
        send_request(fqmd_pkg::REQ_RATIO, 32'sd7, 32'sd1);
        send_request(fqmd_pkg::REQ_RATIO, 32'sh8000, 32'shFFFF);
        send_request(fqmd_pkg::REQ_RATIO, 32'sd5, 32'shFFFF);
        send_request(fqmd_pkg::REQ_RATIO, 32'sh8000, 32'sd0);
        send_request(fqmd_pkg::REQ_RATIO, 32'sd3, 32'sd0);
        send_request(fqmd_pkg::REQ_RATIO, 32'sh7FFF, 32'sh8000);
        send_request(fqmd_pkg::REQ_RATIO, 32'sh1234_0001, 32'sd3);
        send_request(fqmd_pkg::REQ_DIV, fqmd_pkg::S32_MIN, fqmd_pkg::ONE_Q16);
        send_request(fqmd_pkg::REQ_DIV, fqmd_pkg::S32_MIN, -fqmd_pkg::ONE_Q16);
        send_request(fqmd_pkg::REQ_DIV, 32'sd5, -fqmd_pkg::ONE_Q16);
        send_request(fqmd_pkg::REQ_DIV, -32'sd1, 32'sd0);
        send_request(fqmd_pkg::REQ_DIV, 32'sd0, 32'sd0);
        send_request(fqmd_pkg::REQ_DIV, fqmd_pkg::S32_MAX, 32'sd1);
        send_request(fqmd_pkg::REQ_DIV, fqmd_pkg::S32_MIN, 32'sd1);
        send_request(fqmd_pkg::REQ_DIV, 32'sd3, -32'sd2);
        send_request(fqmd_pkg::REQ_DIV, fqmd_pkg::S32_MIN, fqmd_pkg::S32_MIN);
        send_request(2'd3, 32'sd1, 32'sd2);
    endtask

    // random requests across all kinds
    task automatic test_random(input int count);
        repeat (count) send_request(2'($urandom_range(3)), rand_operand(), rand_operand());
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        hold_receiver = 1'b1;
        idle_pct = 0;
        test_random(120);
        hold_receiver = 1'b0;
        idle_pct = 21;
    endtask

    // stimulus
    initial begin
        n_errors = 0; n_results = 0; n_requests = 0;
        idle_pct = 21;
        hold_receiver = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        // no idling on either side for a while
        idle_pct = 0;
        test_random(200);
        idle_pct = 21;
        test_backpressure();
        test_random(300);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d requests: multiply, ratio, divide, unused kind and stalls",
                 n_requests);
        $display("checked %0d results", n_results);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* fixed_16_16_mul_ratio_div_unit.f */
hdl/fqmd_pkg.sv
hdl/fqmd_front.sv
hdl/fqmd_queue.sv
hdl/fqmd_back.sv
hdl/fixed_16_16_mul_ratio_div_unit.sv
tb/tb.sv
